[hdl/mlr_pkg.sv]
// mlr_pkg: shared types and constants for the midpoint line rasterizer.
// No dependencies; imported by midpoint_line_rasterizer_core and mlr_checker.
package mlr_pkg;

  // Coordinate space is fixed at 512 x 512 by the 9-bit endpoint fields.
  localparam int unsigned ImageSize = 512;
  localparam int unsigned CoordW    = $clog2(ImageSize);
  localparam int unsigned ColorW    = 24;
  localparam int unsigned DeltaW    = CoordW + 1;
  localparam int unsigned DecW      = 12;

  typedef logic [CoordW-1:0]      coord_t;
  typedef logic [ColorW-1:0]      color_t;
  typedef logic [DeltaW-1:0]      delta_t;
  typedef logic signed [DecW-1:0] dec_t;

  // Input command codes.
  typedef enum logic {
    FuncLoad = 1'b0,
    FuncStep = 1'b1
  } func_e;

endpackage

[hdl/midpoint_line_rasterizer_core.sv]
// midpoint_line_rasterizer_core: midpoint line stepper, one pixel per step transfer on an active line.
// Depends on mlr_pkg (types, widths, command codes).
//
//   channel | direction | fields                                        | handshake
//   --------+-----------+-----------------------------------------------+-----------------------
//   in      | input     | func, start_x, start_y, end_x, end_y, color   | in_valid_i/in_ready_o
//   out     | output    | pixel_x, pixel_y, pixel_color, last_pixel     | out_valid_o/out_ready_i
//
// Cycles: one in transfer per clock while in_ready_o is high; a step transfer while a line is active
//   produces its pixel in the output register on the next clock.
// Load transfers set up the line in the same clock and produce no pixel.
// A single output register decouples the sides: in_ready_o is high when the
//   register is empty or is being drained in the same clock.
// Reset (rst_ni low, asynchronous) clears the active flag and output valid.
module midpoint_line_rasterizer_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input channel
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            func_i,
  input  mlr_pkg::coord_t start_x_i,
  input  mlr_pkg::coord_t start_y_i,
  input  mlr_pkg::coord_t end_x_i,
  input  mlr_pkg::coord_t end_y_i,
  input  mlr_pkg::color_t line_color_i,
  // output channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mlr_pkg::coord_t pixel_x_o,
  output mlr_pkg::coord_t pixel_y_o,
  output mlr_pkg::color_t pixel_color_o,
  output logic            last_pixel_o
);
  import mlr_pkg::*;

  // ---------------------------------------------------------------------------
  // Line state
  // ---------------------------------------------------------------------------
  logic   busy_q,        busy_d;
  logic   steep_q,       steep_d;
  coord_t major_pos_q,   major_pos_d;
  coord_t minor_pos_q,   minor_pos_d;
  coord_t major_end_q,   major_end_d;
  dec_t   decision_q,    decision_d;
  delta_t delta_major_q, delta_major_d;
  delta_t delta_minor_q, delta_minor_d;
  logic   minor_down_q,  minor_down_d;
  color_t held_color_q,  held_color_d;

  // Output register
  logic   out_valid_q,   out_valid_d;
  coord_t pixel_x_q,     pixel_x_d;
  coord_t pixel_y_q,     pixel_y_d;
  color_t pixel_color_q, pixel_color_d;
  logic   last_pixel_q,  last_pixel_d;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic in_xfer, out_xfer, is_load, is_step, emit;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_xfer    = in_valid_i & in_ready_o;
  assign out_xfer   = out_valid_q & out_ready_i;
  assign is_load    = in_xfer & (func_i == FuncLoad);
  assign is_step    = in_xfer & (func_i == FuncStep);
  // A step with no active line is swallowed without a pixel.
  assign emit       = is_step & busy_q;

  // ---------------------------------------------------------------------------
  // Load setup: octant fold and decision seed
  // ---------------------------------------------------------------------------
  logic signed [CoordW:0] raw_dx, raw_dy, raw_dys;
  coord_t abs_dx, abs_dy;
  logic   ld_steep;
  coord_t ax_s, ay_s, bx_s, by_s;   // after steep swap
  coord_t ax_o, ay_o, bx_o, by_o;   // after left-to-right ordering
  coord_t ld_dx, ld_dy;
  logic   ld_down;
  dec_t   seed_n, seed_r, ld_seed;

  always_comb begin
    raw_dx   = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
    raw_dy   = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
    abs_dx   = raw_dx[CoordW] ? coord_t'(-raw_dx) : coord_t'(raw_dx);
    abs_dy   = raw_dy[CoordW] ? coord_t'(-raw_dy) : coord_t'(raw_dy);
    ld_steep = abs_dx < abs_dy;

    // make x the major axis
    if (ld_steep) begin
      ax_s = start_y_i; ay_s = start_x_i;
      bx_s = end_y_i;   by_s = end_x_i;
    end else begin
      ax_s = start_x_i; ay_s = start_y_i;
      bx_s = end_x_i;   by_s = end_y_i;
    end

    // walk along increasing major coordinate
    if (bx_s < ax_s) begin
      ax_o = bx_s; ay_o = by_s;
      bx_o = ax_s; by_o = ay_s;
    end else begin
      ax_o = ax_s; ay_o = ay_s;
      bx_o = bx_s; by_o = by_s;
    end

    ld_dx   = bx_o - ax_o;
    raw_dys = $signed({1'b0, by_o}) - $signed({1'b0, ay_o});
    ld_down = raw_dys[CoordW];
    ld_dy   = ld_down ? coord_t'(-raw_dys) : coord_t'(raw_dys);

    // seed = (dx - 2*dy) / 2, rounded toward zero
    seed_n  = dec_t'({{(DecW-CoordW){1'b0}}, ld_dx})
            - dec_t'({{(DecW-CoordW-1){1'b0}}, ld_dy, 1'b0});
    seed_r  = seed_n + dec_t'({{(DecW-1){1'b0}}, seed_n[DecW-1]});
    ld_seed = {seed_r[DecW-1], seed_r[DecW-1:1]};
  end

  // ---------------------------------------------------------------------------
  // Step: emit current pixel, then, unless it is the last, advance one major step
  // ---------------------------------------------------------------------------
  logic at_end;
  dec_t dmaj_ext, dmin_ext;

  assign at_end   = major_pos_q == major_end_q;
  assign dmaj_ext = dec_t'({{(DecW-DeltaW){1'b0}}, delta_major_q});
  assign dmin_ext = dec_t'({{(DecW-DeltaW){1'b0}}, delta_minor_q});

  always_comb begin
    busy_d        = busy_q;
    steep_d       = steep_q;
    major_pos_d   = major_pos_q;
    minor_pos_d   = minor_pos_q;
    major_end_d   = major_end_q;
    decision_d    = decision_q;
    delta_major_d = delta_major_q;
    delta_minor_d = delta_minor_q;
    minor_down_d  = minor_down_q;
    held_color_d  = held_color_q;

    if (is_load) begin
      // a load abandons any line in progress
      busy_d        = 1'b1;
      steep_d       = ld_steep;
      major_pos_d   = ax_o;
      minor_pos_d   = ay_o;
      major_end_d   = bx_o;
      decision_d    = ld_seed;
      delta_major_d = {1'b0, ld_dx};
      delta_minor_d = {1'b0, ld_dy};
      minor_down_d  = ld_down;
      held_color_d  = line_color_i;
    end else if (emit) begin
      if (at_end) begin
        busy_d = 1'b0;
      end else begin
        major_pos_d = major_pos_q + coord_t'(1);
        if (decision_q[DecW-1]) begin
          minor_pos_d = minor_down_q ? minor_pos_q - coord_t'(1)
                                     : minor_pos_q + coord_t'(1);
          decision_d  = decision_q + dmaj_ext - dmin_ext;
        end else begin
          decision_d  = decision_q - dmin_ext;
        end
      end
    end
  end

  // output register: new pixel, drain, or hold
  always_comb begin
    out_valid_d   = out_valid_q;
    pixel_x_d     = pixel_x_q;
    pixel_y_d     = pixel_y_q;
    pixel_color_d = pixel_color_q;
    last_pixel_d  = last_pixel_q;
    if (emit) begin
      out_valid_d   = 1'b1;
      pixel_x_d     = steep_q ? minor_pos_q : major_pos_q;
      pixel_y_d     = steep_q ? major_pos_q : minor_pos_q;
      pixel_color_d = held_color_q;
      last_pixel_d  = at_end;
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath state; only read once loaded / valid
  always_ff @(posedge clk_i) begin
    steep_q       <= steep_d;
    major_pos_q   <= major_pos_d;
    minor_pos_q   <= minor_pos_d;
    major_end_q   <= major_end_d;
    decision_q    <= decision_d;
    delta_major_q <= delta_major_d;
    delta_minor_q <= delta_minor_d;
    minor_down_q  <= minor_down_d;
    held_color_q  <= held_color_d;
    pixel_x_q     <= pixel_x_d;
    pixel_y_q     <= pixel_y_d;
    pixel_color_q <= pixel_color_d;
    last_pixel_q  <= last_pixel_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign pixel_color_o = pixel_color_q;
  assign last_pixel_o  = last_pixel_q;

endmodule

[hdl/mlr_checker.sv]
// mlr_checker: port-level assertions for midpoint_line_rasterizer_core, plus bind.
// Depends on mlr_pkg and the top level's port list.
module mlr_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            func_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input mlr_pkg::coord_t pixel_x_o,
  input mlr_pkg::coord_t pixel_y_o,
  input mlr_pkg::color_t pixel_color_o,
  input logic            last_pixel_o
);
  import mlr_pkg::*;

  // stalled pixel stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped before transfer");

  // stalled pixel keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pixel_x_o) && $stable(pixel_y_o)
                                    && $stable(pixel_color_o) && $stable(last_pixel_o))
    else $error("output payload changed while stalled");

  // empty output stage never backpressures
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("in_ready_o low with empty output");

  // a load never produces a pixel
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == FuncLoad) && !out_valid_o |=> !out_valid_o)
    else $error("pixel produced by a load transfer");

endmodule

bind midpoint_line_rasterizer_core mlr_checker u_mlr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .func_i        (func_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_x_o     (pixel_x_o),
  .pixel_y_o     (pixel_y_o),
  .pixel_color_o (pixel_color_o),
  .last_pixel_o  (last_pixel_o)
);
